FILE: src/ftpt_pkg.sv
// Shared types and constants of the format translation path table.
`default_nettype none
package ftpt_pkg;
  localparam int unsigned NumFormats = 32;
  localparam int unsigned NumAudio = 16;
  localparam int unsigned FmtW = $clog2(NumFormats);
  localparam int unsigned IdxW = 2 * FmtW;
  localparam int unsigned Depth = NumFormats * NumFormats;
  localparam int unsigned NaEff = (NumAudio < 16) ? NumAudio : 16;
  localparam int unsigned NaW = (NaEff > 1) ? $clog2(NaEff) : 1;
  localparam int unsigned CostW = 32;
  localparam int unsigned TidW = 8;
  localparam int unsigned InDataW = 88;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [2:0] {
    ReqClear = 3'd0,
    ReqOffer = 3'd1,
    ReqClose = 3'd2,
    ReqQuery = 3'd3,
    ReqBest  = 3'd4
  } req_e;

  // one table entry as stored
  typedef struct packed {
    logic             valid;
    logic             multi;
    logic [TidW-1:0]  tid;
    logic [CostW-1:0] cost;
  } entry_t;

  typedef struct packed {
    logic            found;
    logic [CostW-1:0] cost;
    logic [TidW-1:0] tid;
    logic [1:0]      steps;
    logic [15:0]     smask;
    logic [15:0]     dmask;
    logic            changed;
  } result_t;

  function automatic logic [CostW-1:0] sat_add(logic [CostW-1:0] a, logic [CostW-1:0] b);
    logic [CostW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostW] ? {CostW{1'b1}} : s[CostW-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: src/ftpt_table_mem.sv
// Path table storage: registered-read entry memory; valid bits sit in the entries and are cleared by the controller.
`default_nettype none
module ftpt_table_mem (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [ftpt_pkg::IdxW-1:0] raddr_i,
  output ftpt_pkg::entry_t              rdata_o,
  input  wire logic                     we_i,
  input  wire logic [ftpt_pkg::IdxW-1:0] waddr_i,
  input  wire ftpt_pkg::entry_t         wdata_i
);
  // valid and multi live in the memory; the controller clears them by sweep
  ftpt_pkg::entry_t mem_q [ftpt_pkg::Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule
`default_nettype wire

FILE: src/ftpt_ctrl.sv
// Request sequencer: offer, query, closure passes, best choice and clearing sweep.
`default_nettype none
module ftpt_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  output logic                              req_ready_o,
  input  wire logic [ftpt_pkg::InDataW-1:0] req_data_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output ftpt_pkg::result_t                 res_o,
  output logic [ftpt_pkg::IdxW-1:0]         raddr_o,
  input  wire ftpt_pkg::entry_t             rdata_i,
  output logic                              we_o,
  output logic [ftpt_pkg::IdxW-1:0]         waddr_o,
  output ftpt_pkg::entry_t                  wdata_o
);
  localparam int unsigned FW = ftpt_pkg::FmtW;
  localparam int unsigned NW = ftpt_pkg::NaW;
  localparam logic [3:0] SInit  = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SOne   = 4'd2;  // offer/query read issued
  localparam logic [3:0] SOneW  = 4'd3;
  localparam logic [3:0] SCxy   = 4'd4;  // closure: read x->y
  localparam logic [3:0] SCyz   = 4'd5;
  localparam logic [3:0] SCxz   = 4'd6;
  localparam logic [3:0] SCev   = 4'd7;
  localparam logic [3:0] SCwb   = 4'd8;
  localparam logic [3:0] SBrd   = 4'd9;
  localparam logic [3:0] SBev   = 4'd10;
  localparam logic [3:0] SOut   = 4'd11;
  localparam logic [3:0] SClr   = 4'd12;
  localparam logic [3:0] SBwt   = 4'd13;

  logic [3:0] st_q, st_d;
  logic [2:0] req_q;
  logic [FW-1:0] sf_q, df_q;
  logic in_range_q;
  logic [31:0] ecost_q;
  logic [7:0] tid_q;
  logic act_q;
  logic [15:0] sm_q, dm_q;
  logic [FW-1:0] x_q, y_q, z_q;
  logic [ftpt_pkg::IdxW-1:0] clr_q;
  logic pass_chg_q, any_chg_q;
  ftpt_pkg::entry_t exy_q, eyz_q, exz_q;
  logic [NW-1:0] cx_q, cy_q;
  logic have_q;
  ftpt_pkg::result_t res_q;
  logic busy_out_q;

  // offsets into the input beat
  logic [2:0] in_req;
  logic [4:0] in_sf, in_df;
  assign in_req = req_data_i[2:0];
  assign in_sf  = req_data_i[7:3];
  assign in_df  = req_data_i[12:8];

  assign req_ready_o = (st_q == SIdle) && !busy_out_q;
  assign res_valid_o = busy_out_q;
  assign res_o = res_q;

  logic [ftpt_pkg::IdxW-1:0] idx_one, idx_xy, idx_yz, idx_xz, idx_b;
  assign idx_one = {sf_q, df_q};
  assign idx_xy = {x_q, y_q};
  assign idx_yz = {y_q, z_q};
  assign idx_xz = {x_q, z_q};
  assign idx_b  = {FW'(cx_q), FW'(cy_q)};

  logic [15:0] amask, common, lowbit;
  assign amask = (ftpt_pkg::NaEff >= 16) ? 16'hFFFF : 16'((32'd1 << ftpt_pkg::NaEff) - 32'd1);
  assign common = sm_q & dm_q & amask;
  assign lowbit = common & (~common + 16'd1);

  // closure walks every (x,y,z); triples with a repeated index never write
  logic last_z, last_y, last_x, last_cx, last_cy, pass_end;
  assign last_z = (z_q == FW'(ftpt_pkg::NumFormats - 1));
  assign last_y = (y_q == FW'(ftpt_pkg::NumFormats - 1));
  assign last_x = (x_q == FW'(ftpt_pkg::NumFormats - 1));
  assign last_cx = (cx_q == NW'(ftpt_pkg::NaEff - 1));
  assign last_cy = (cy_q == NW'(ftpt_pkg::NaEff - 1));
  assign pass_end = last_x && last_y && last_z;

  logic cand_ok;
  assign cand_ok = sm_q[cx_q] && dm_q[cy_q] &&
                   (32'(cx_q) < ftpt_pkg::NumFormats) && (32'(cy_q) < ftpt_pkg::NumFormats);

  always_comb begin
    st_d = st_q;
    raddr_o = idx_one;
    we_o = 1'b0;
    waddr_o = idx_one;
    wdata_o = '0;
    unique case (st_q)
      SInit, SClr: begin
        we_o = 1'b1;
        waddr_o = clr_q;
        if (clr_q == ftpt_pkg::IdxW'(ftpt_pkg::Depth - 1)) st_d = (st_q == SInit) ? SIdle : SOut;
      end
      SIdle: ;
      SOne: st_d = SOneW;
      SOneW: begin
        if (req_q == ftpt_pkg::ReqOffer && act_q && in_range_q &&
            (!rdata_i.valid || ecost_q < rdata_i.cost)) begin
          we_o = 1'b1;
          wdata_o = '{valid: 1'b1, multi: 1'b0, tid: tid_q, cost: ecost_q};
        end
        st_d = SOut;
      end
      SCxy: begin raddr_o = idx_xy; st_d = SCyz; end
      SCyz: begin raddr_o = idx_yz; st_d = SCxz; end
      SCxz: begin raddr_o = idx_xz; st_d = SCev; end
      SCev: st_d = SCwb;
      SCwb: begin
        st_d = SCxy;
        if ((x_q != y_q) && (z_q != x_q) && (z_q != y_q) && exy_q.valid && eyz_q.valid &&
            (!exz_q.valid || ftpt_pkg::sat_add(exy_q.cost, eyz_q.cost) < exz_q.cost)) begin
          we_o = 1'b1;
          waddr_o = idx_xz;
          wdata_o = '{valid: 1'b1, multi: 1'b1, tid: exy_q.tid,
                      cost: ftpt_pkg::sat_add(exy_q.cost, eyz_q.cost)};
        end
      end
      SBrd: begin raddr_o = idx_b; st_d = SBwt; end
      SBwt: begin raddr_o = idx_b; st_d = SBev; end
      SBev: st_d = SBrd;
      SOut: ;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SInit;
      clr_q <= '0;
      busy_out_q <= 1'b0;
      x_q <= '0; y_q <= '0; z_q <= '0;
      cx_q <= '0; cy_q <= '0;
      have_q <= 1'b0;
      pass_chg_q <= 1'b0;
      any_chg_q <= 1'b0;
    end else begin
      if (busy_out_q && res_ready_i) busy_out_q <= 1'b0;
      unique case (st_q)
        SInit, SClr: begin
          clr_q <= clr_q + ftpt_pkg::IdxW'(1);
          st_q <= st_d;
          if (st_q == SClr && clr_q == ftpt_pkg::IdxW'(ftpt_pkg::Depth - 1)) res_q <= '0;
        end
        SIdle: begin
          if (req_valid_i && req_ready_o) begin
            req_q <= in_req;
            sf_q <= FW'(in_sf);
            df_q <= FW'(in_df);
            in_range_q <= (32'(in_sf) < ftpt_pkg::NumFormats) &&
                          (32'(in_df) < ftpt_pkg::NumFormats);
            ecost_q <= req_data_i[44:13];
            tid_q <= req_data_i[52:45];
            act_q <= req_data_i[53];
            sm_q <= req_data_i[69:54];
            dm_q <= req_data_i[85:70];
            res_q <= '0;
            x_q <= '0; y_q <= '0; z_q <= '0;
            cx_q <= '0; cy_q <= '0;
            have_q <= 1'b0;
            pass_chg_q <= 1'b0;
            any_chg_q <= 1'b0;
            clr_q <= '0;
            unique case (in_req)
              ftpt_pkg::ReqClear: st_q <= SClr;
              ftpt_pkg::ReqOffer, ftpt_pkg::ReqQuery: st_q <= SOne;
              ftpt_pkg::ReqClose: st_q <= SCxy;
              ftpt_pkg::ReqBest: st_q <= SBrd;
              default: st_q <= SOut;
            endcase
          end
        end
        SOne: st_q <= st_d;
        SOneW: begin
          if (req_q == ftpt_pkg::ReqOffer) begin
            res_q.changed <= we_o;
          end else if (in_range_q && rdata_i.valid) begin
            res_q.found <= 1'b1;
            res_q.cost <= rdata_i.cost;
            res_q.tid <= rdata_i.tid;
            res_q.steps <= rdata_i.multi ? 2'd2 : 2'd1;
          end
          st_q <= SOut;
        end
        SCxy: st_q <= SCyz;
        SCyz: begin exy_q <= rdata_i; st_q <= SCxz; end
        SCxz: begin eyz_q <= rdata_i; st_q <= SCev; end
        SCev: begin exz_q <= rdata_i; st_q <= SCwb; end
        SCwb: begin
          if (!pass_end) begin
            if (we_o) pass_chg_q <= 1'b1;
            st_q <= SCxy;
          end else begin
            pass_chg_q <= 1'b0;
            if (pass_chg_q || we_o) begin
              any_chg_q <= 1'b1;
              st_q <= SCxy;
            end else begin
              res_q.changed <= any_chg_q;
              st_q <= SOut;
            end
          end
          if (!last_z) z_q <= z_q + FW'(1);
          else begin
            z_q <= '0;
            if (!last_y) y_q <= y_q + FW'(1);
            else begin
              y_q <= '0;
              if (!last_x) x_q <= x_q + FW'(1);
              else x_q <= '0;
            end
          end
        end
        SBrd: begin
          if (common != 16'd0) begin
            res_q.found <= 1'b1;
            res_q.smask <= lowbit;
            res_q.dmask <= lowbit;
            st_q <= SOut;
          end else st_q <= SBwt;
        end
        SBwt: st_q <= SBev;
        SBev: begin
          if (cand_ok && rdata_i.valid &&
              (!have_q || rdata_i.cost < res_q.cost ||
               (rdata_i.cost == res_q.cost && !rdata_i.multi && res_q.steps == 2'd2))) begin
            have_q <= 1'b1;
            res_q.found <= 1'b1;
            res_q.cost <= rdata_i.cost;
            res_q.tid <= rdata_i.tid;
            res_q.steps <= rdata_i.multi ? 2'd2 : 2'd1;
            res_q.smask <= 16'd1 << cx_q;
            res_q.dmask <= 16'd1 << cy_q;
          end
          if (!last_cx) begin
            cx_q <= cx_q + NW'(1);
            st_q <= SBrd;
          end else begin
            cx_q <= '0;
            if (!last_cy) begin
              cy_q <= cy_q + NW'(1);
              st_q <= SBrd;
            end else st_q <= SOut;
          end
        end
        SOut: begin
          if (!busy_out_q) begin
            busy_out_q <= 1'b1;
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/format_translation_path_table_core.sv
// Top level of the format translation path table.
`default_nettype none
// Format translation path table. One request beat in, one result beat out.
// After reset a clearing pass over every table entry runs before the first beat is taken.
// Offer and query read one entry; clear sweeps the whole table; best choice
// answers at once when the masks share an audio bit, else reads each audio-bit
// pair in turn; close reads x->y, y->z and x->z for every (x,y,z) triple, pass
// after pass over the table memory, repeated until a pass changes nothing.
module format_translation_path_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // req_type, src_format, dst_format, edge_cost, translator_id, edge_active,
  // src_mask, dst_mask, zero pad
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // path_found, path_cost, first_translator, step_count, chosen_src_mask,
  // chosen_dst_mask, table_changed, zero pad
  output logic [79:0]      m_axis_tdata
);
  ftpt_pkg::entry_t rdata, wdata;
  logic [ftpt_pkg::IdxW-1:0] raddr, waddr;
  logic we;
  ftpt_pkg::result_t res;

  ftpt_table_mem u_mem (
    .clk_i, .rst_ni, .raddr_i(raddr), .rdata_o(rdata),
    .we_i(we), .waddr_i(waddr), .wdata_i(wdata)
  );

  ftpt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_ready_o(s_axis_tready), .req_data_i(s_axis_tdata),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res),
    .raddr_o(raddr), .rdata_i(rdata), .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  assign m_axis_tdata = {4'd0, res.changed, res.dmask, res.smask, res.steps, res.tid,
                         res.cost, res.found};
endmodule
`default_nettype wire

FILE: src/ftpt_checker.sv
// Port-level checker of the path table and its bind.
`default_nettype none
module ftpt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("back-to-back take");
  a_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[42:41] != 2'd3) else $error("bad step count");
endmodule
bind format_translation_path_table_core ftpt_checker u_chk (.*);
`default_nettype wire
